[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with reset disable
`define VRU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define VRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/vru_pkg.sv]
// ----------------------------------------------------------------------------
// vru_pkg
// Shared constants and types of the vector refraction unit.
// ----------------------------------------------------------------------------
package vru_pkg;

	localparam int FRAC_W     = 14;               // fraction bits of vector values
	localparam int ETA_W      = 16;               // index ratio width
	localparam int ETA_FRAC_W = 13;               // index ratio fraction bits
	localparam int OUT_W      = 20;               // result component width
	localparam int SQ_OUT_W   = 25;               // square root result bits
	localparam int SQ_IN_W    = 2 * SQ_OUT_W;     // radicand bits

	localparam longint ONE     = 64'sd16384;              // 1.0 in q.14
	localparam longint C_MIN   = -64'sd2147483648;        // cosine floor
	localparam longint W_LIM   = 64'sd1099511627776;      // bound on d + c*n
	localparam longint P_LIM   = 64'sd16777216;           // bound on perpendicular part
	localparam longint RAD_ONE = 64'sd268435456;          // 1.0 in q.28
	localparam longint OUT_MAX = 64'sd524287;
	localparam longint OUT_MIN = -64'sd524288;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

[rtl/vru_in_if.sv]
// ----------------------------------------------------------------------------
// vru_in_if
// Ray channel: incident direction, surface normal and index ratio.
// ----------------------------------------------------------------------------
interface vru_in_if #(
	parameter int COMP_WIDTH = 16
);
	logic                               valid;
	logic                               ready;
	logic signed [COMP_WIDTH-1:0]       dir_x;
	logic signed [COMP_WIDTH-1:0]       dir_y;
	logic signed [COMP_WIDTH-1:0]       dir_z;
	logic signed [COMP_WIDTH-1:0]       norm_x;
	logic signed [COMP_WIDTH-1:0]       norm_y;
	logic signed [COMP_WIDTH-1:0]       norm_z;
	logic        [vru_pkg::ETA_W-1:0]   eta_ratio;

	modport source (
		output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		input  ready
	);

	modport sink (
		input  valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		output ready
	);
endinterface

[rtl/vru_out_if.sv]
// ----------------------------------------------------------------------------
// vru_out_if
// Result channel: refracted direction and saturation flag.
// ----------------------------------------------------------------------------
interface vru_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [vru_pkg::OUT_W-1:0]   ref_x;
	logic signed [vru_pkg::OUT_W-1:0]   ref_y;
	logic signed [vru_pkg::OUT_W-1:0]   ref_z;
	logic                               clipped;

	modport source (
		output valid, ref_x, ref_y, ref_z, clipped,
		input  ready
	);

	modport sink (
		input  valid, ref_x, ref_y, ref_z, clipped,
		output ready
	);
endinterface

[rtl/vru_isqrt.sv]
// ----------------------------------------------------------------------------
// vru_isqrt
// Pipelined integer square root, one result bit per stage, with a
// side-band word that travels alongside.
// ----------------------------------------------------------------------------
module vru_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vru_pkg::pipe_ctl_t              ctl,
	input  logic [vru_pkg::SQ_IN_W-1:0]     rad,
	input  logic [SIDE_W-1:0]               side_in,
	output logic                            vld,
	output logic [vru_pkg::SQ_OUT_W-1:0]    root,
	output logic [SIDE_W-1:0]               side_out
);
	localparam int N  = vru_pkg::SQ_OUT_W;
	localparam int XB = vru_pkg::SQ_IN_W;
	localparam int RW = N + 3;

	logic [RW-1:0]     rem_s  [N];
	logic [N-1:0]      root_s [N];
	logic [XB-1:0]     x_s    [N];
	logic [SIDE_W-1:0] side_s [N];
	logic [N-1:0]      v_s;

	logic [RW-1:0]     rem_i  [N];
	logic [N-1:0]      root_i [N];
	logic [XB-1:0]     x_i    [N];
	logic [RW-1:0]     cur    [N];
	logic [RW-1:0]     trial  [N];

	always_comb begin
		rem_i[0]  = '0;
		root_i[0] = '0;
		x_i[0]    = rad;
		for (int k = 1; k < N; k++) begin
			rem_i[k]  = rem_s[k-1];
			root_i[k] = root_s[k-1];
			x_i[k]    = x_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			// bring down the next two radicand bits
			cur[k]   = {rem_i[k][RW-3:0], x_i[k][XB-1 -: 2]};
			trial[k] = RW'({root_i[k], 2'b01});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < N; k++) begin
				x_s[k] <= x_i[k] << 2;
				if (cur[k] >= trial[k]) begin
					rem_s[k]  <= cur[k] - trial[k];
					root_s[k] <= {root_i[k][N-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur[k];
					root_s[k] <= {root_i[k][N-2:0], 1'b0};
				end
			end
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (ctl.en) begin
			v_s <= {v_s[N-2:0], ctl.vld};
		end
	end

	assign vld      = v_s[N-1];
	assign root     = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

[rtl/vector_refraction_unit.sv]
// ----------------------------------------------------------------------------
// vector_refraction_unit
// Snell refraction of a unit direction about a unit normal, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   incident  (sink)   one ray per beat: direction and normal in signed q.14
//                      at COMP_WIDTH bits, index ratio in unsigned q3.13
//   refracted (source) one result per beat: refracted direction in signed
//                      q5.14 at 20 bits and a flag that is set when any
//                      component or intermediate value saturated
//   An accepted ray beat passes ten arithmetic stages plus 25 stages of
//   the square root, which makes one result bit per stage, on its way to
//   its result beat.
//   Throughput is one ray per cycle unless a waiting result stalls the
//   pipeline; rays are independent and results leave in arrival order.
//   Reset clears every valid bit; no results are pending after it.
//   While a result waits and refracted.ready is low the whole pipeline
//   holds, and incident.ready drops in the same cycle; bubbles inside the
//   pipeline are not squeezed out during the hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_refraction_unit #(
	parameter int COMP_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	vru_in_if.sink   incident,
	vru_out_if.source refracted
);
	localparam int W    = COMP_WIDTH;
	localparam int FR   = vru_pkg::FRAC_W;
	localparam int EW   = vru_pkg::ETA_W;
	localparam int EFR  = vru_pkg::ETA_FRAC_W;
	localparam int OUTW = vru_pkg::OUT_W;
	localparam int SQN  = vru_pkg::SQ_OUT_W;
	localparam int SQI  = vru_pkg::SQ_IN_W;

	localparam int PRW  = 2 * W;
	localparam int SUMW = PRW + 2;
	localparam int NDW  = SUMW - FR + 1;
	localparam int CW   = (NDW > 32) ? 32 : ((NDW < 16) ? 16 : NDW);
	localparam int XW   = (NDW > 34) ? NDW : 34;
	localparam int CPW  = CW + W;
	localparam int WR   = CPW - FR + 1;
	localparam int WW   = (WR > 42) ? 42 : WR;
	localparam int YW   = (WR > 43) ? WR : 43;
	localparam int EPW  = WW + EW + 1;
	localparam int PR   = EPW - EFR;
	localparam int PPW  = (PR > 26) ? 26 : PR;
	localparam int ZW   = (PR > 27) ? PR : 27;
	localparam int SQPW = 2 * PPW;
	localparam int SSW  = SQPW + 2;
	localparam int DW   = (SSW > 30) ? SSW + 1 : 31;
	localparam int RNW  = SQN + 1 + W;
	localparam int NMW  = RNW + 1;
	localparam int PARW = NMW - FR;
	localparam int OW   = ((PARW > PPW) ? PARW : PPW) + 1;
	localparam int QW   = (OW > 21) ? OW : 21;
	localparam int SIDE_W = 1 + 3 * PPW + 3 * W;

	localparam logic signed [XW-1:0]  C_ONE_X = XW'(vru_pkg::ONE);
	localparam logic signed [XW-1:0]  C_MIN_X = XW'(vru_pkg::C_MIN);
	localparam logic signed [CW-1:0]  C_ONE_C = CW'(vru_pkg::ONE);
	localparam logic signed [YW-1:0]  W_HI    = YW'(vru_pkg::W_LIM);
	localparam logic signed [YW-1:0]  W_LO    = -YW'(vru_pkg::W_LIM);
	localparam logic signed [ZW-1:0]  P_HI    = ZW'(vru_pkg::P_LIM);
	localparam logic signed [ZW-1:0]  P_LO    = -ZW'(vru_pkg::P_LIM);
	localparam logic signed [DW-1:0]  R_ONE   = DW'(vru_pkg::RAD_ONE);
	localparam logic signed [QW-1:0]  O_HI    = QW'(vru_pkg::OUT_MAX);
	localparam logic signed [QW-1:0]  O_LO    = QW'(vru_pkg::OUT_MIN);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s34, v_s35;

	// one global advance: the pipeline moves unless a result is stuck
	assign en             = !v_s35 || refracted.ready;
	assign incident.ready = en;

	logic signed [W-1:0] d_in [3];
	logic signed [W-1:0] n_in [3];

	assign d_in[0] = incident.dir_x;
	assign d_in[1] = incident.dir_y;
	assign d_in[2] = incident.dir_z;
	assign n_in[0] = incident.norm_x;
	assign n_in[1] = incident.norm_y;
	assign n_in[2] = incident.norm_z;

	// ---------------- stage 1: d_i * n_i
	logic signed [W-1:0]   d_s1 [3];
	logic signed [W-1:0]   n_s1 [3];
	logic signed [PRW-1:0] dn_s1 [3];
	logic [EW-1:0]         eta_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= d_in[i];
				n_s1[i]  <= n_in[i];
				dn_s1[i] <= PRW'(d_in[i]) * PRW'(n_in[i]);
			end
			eta_s1 <= incident.eta_ratio;
		end
	end

	// ---------------- stage 2: dot product, cosine clamp
	logic signed [SUMW-1:0] dot_sum;
	logic signed [SUMW-1:0] dot_q14;
	logic signed [NDW-1:0]  neg_dot;
	logic signed [XW-1:0]   nd_x;
	logic signed [XW-1:0]   c_x;
	logic                   c_clip;

	always_comb begin
		dot_sum = SUMW'(dn_s1[0]) + SUMW'(dn_s1[1]) + SUMW'(dn_s1[2]);
		dot_q14 = dot_sum >>> FR;
		neg_dot = -NDW'(dot_q14);
		nd_x    = XW'(neg_dot);
		c_clip  = 1'b0;
		if (nd_x > C_ONE_X) begin
			c_x = C_ONE_X;
		end else if (nd_x < C_MIN_X) begin
			c_x    = C_MIN_X;
			c_clip = 1'b1;
		end else begin
			c_x = nd_x;
		end
	end

	logic signed [CW-1:0] c_s2;
	logic signed [W-1:0]  d_s2 [3];
	logic signed [W-1:0]  n_s2 [3];
	logic [EW-1:0]        eta_s2;
	logic                 cf_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= CW'(c_x);
			cf_s2  <= c_clip;
			d_s2   <= d_s1;
			n_s2   <= n_s1;
			eta_s2 <= eta_s1;
		end
	end

	// ---------------- stage 3: c * n_i
	logic signed [CPW-1:0] cn_s3 [3];
	logic signed [W-1:0]   d_s3 [3];
	logic signed [W-1:0]   n_s3 [3];
	logic [EW-1:0]         eta_s3;
	logic                  cf_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cn_s3[i] <= CPW'(c_s2) * CPW'(n_s2[i]);
			end
			d_s3   <= d_s2;
			n_s3   <= n_s2;
			eta_s3 <= eta_s2;
			cf_s3  <= cf_s2;
		end
	end

	// ---------------- stage 4: w_i = d_i + c*n_i, saturated
	logic signed [CPW-1:0] cn_sh [3];
	logic signed [WR-1:0]  w_raw [3];
	logic signed [YW-1:0]  w_x   [3];
	logic signed [YW-1:0]  w_c   [3];
	logic [2:0]            w_clip;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cn_sh[i] = cn_s3[i] >>> FR;
			w_raw[i] = WR'(d_s3[i]) + WR'(cn_sh[i]);
			w_x[i]   = YW'(w_raw[i]);
			w_clip[i] = 1'b0;
			if (w_x[i] > W_HI) begin
				w_c[i]    = W_HI;
				w_clip[i] = 1'b1;
			end else if (w_x[i] < W_LO) begin
				w_c[i]    = W_LO;
				w_clip[i] = 1'b1;
			end else begin
				w_c[i] = w_x[i];
			end
		end
	end

	logic signed [WW-1:0] w_s4 [3];
	logic signed [W-1:0]  n_s4 [3];
	logic [EW-1:0]        eta_s4;
	logic                 cf_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w_s4[i] <= WW'(w_c[i]);
			end
			n_s4   <= n_s3;
			eta_s4 <= eta_s3;
			cf_s4  <= cf_s3 | (|w_clip);
		end
	end

	// ---------------- stage 5: eta * w_i
	logic signed [EPW-1:0] e_s5 [3];
	logic signed [W-1:0]   n_s5 [3];
	logic                  cf_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e_s5[i] <= EPW'($signed({1'b0, eta_s4})) * EPW'(w_s4[i]);
			end
			n_s5  <= n_s4;
			cf_s5 <= cf_s4;
		end
	end

	// ---------------- stage 6: perpendicular part, saturated
	logic signed [EPW-1:0] e_sh  [3];
	logic signed [PR-1:0]  p_raw [3];
	logic signed [ZW-1:0]  p_x   [3];
	logic signed [ZW-1:0]  p_c   [3];
	logic [2:0]            p_clip;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_sh[i]  = e_s5[i] >>> EFR;
			p_raw[i] = PR'(e_sh[i]);
			p_x[i]   = ZW'(p_raw[i]);
			p_clip[i] = 1'b0;
			if (p_x[i] > P_HI) begin
				p_c[i]    = P_HI;
				p_clip[i] = 1'b1;
			end else if (p_x[i] < P_LO) begin
				p_c[i]    = P_LO;
				p_clip[i] = 1'b1;
			end else begin
				p_c[i] = p_x[i];
			end
		end
	end

	logic signed [PPW-1:0] p_s6 [3];
	logic signed [W-1:0]   n_s6 [3];
	logic                  cf_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s6[i] <= PPW'(p_c[i]);
			end
			n_s6  <= n_s5;
			cf_s6 <= cf_s5 | (|p_clip);
		end
	end

	// ---------------- stage 7: p_i squared
	logic signed [SQPW-1:0] sq_s7 [3];
	logic signed [PPW-1:0]  p_s7 [3];
	logic signed [W-1:0]    n_s7 [3];
	logic                   cf_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= SQPW'(p_s6[i]) * SQPW'(p_s6[i]);
			end
			p_s7  <= p_s6;
			n_s7  <= n_s6;
			cf_s7 <= cf_s6;
		end
	end

	// ---------------- stage 8: radicand |1 - p.p|
	logic signed [SSW-1:0] sq_sum;
	logic signed [DW-1:0]  rad_diff;
	logic signed [DW-1:0]  rad_abs;

	always_comb begin
		sq_sum   = SSW'(sq_s7[0]) + SSW'(sq_s7[1]) + SSW'(sq_s7[2]);
		rad_diff = R_ONE - DW'(sq_sum);
		rad_abs  = (rad_diff < 0) ? -rad_diff : rad_diff;
	end

	logic [SQI-1:0]        rad_s8;
	logic signed [PPW-1:0] p_s8 [3];
	logic signed [W-1:0]   n_s8 [3];
	logic                  cf_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s8 <= SQI'(rad_abs);
			p_s8   <= p_s7;
			n_s8   <= n_s7;
			cf_s8  <= cf_s7;
		end
	end

	// ---------------- stages 9..33: square root
	vru_pkg::pipe_ctl_t  sq_ctl;
	logic [SIDE_W-1:0]   side_in;
	logic [SIDE_W-1:0]   side_out;
	logic                sq_vld;
	logic [SQN-1:0]      sq_root;

	assign sq_ctl.en  = en;
	assign sq_ctl.vld = v_s8;
	assign side_in    = {cf_s8, p_s8[0], p_s8[1], p_s8[2], n_s8[0], n_s8[1], n_s8[2]};

	vru_isqrt #(
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sq_ctl),
		.rad      (rad_s8),
		.side_in  (side_in),
		.vld      (sq_vld),
		.root     (sq_root),
		.side_out (side_out)
	);

	logic signed [PPW-1:0] p_sq [3];
	logic signed [W-1:0]   n_sq [3];
	logic                  cf_sq;

	assign n_sq[2] = $signed(side_out[W-1:0]);
	assign n_sq[1] = $signed(side_out[2*W-1:W]);
	assign n_sq[0] = $signed(side_out[3*W-1:2*W]);
	assign p_sq[2] = $signed(side_out[3*W+PPW-1:3*W]);
	assign p_sq[1] = $signed(side_out[3*W+2*PPW-1:3*W+PPW]);
	assign p_sq[0] = $signed(side_out[3*W+3*PPW-1:3*W+2*PPW]);
	assign cf_sq   = side_out[SIDE_W-1];

	// ---------------- stage 34: r * n_i
	logic signed [RNW-1:0] rn_s34 [3];
	logic signed [PPW-1:0] p_s34 [3];
	logic                  cf_s34;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rn_s34[i] <= RNW'($signed({1'b0, sq_root})) * RNW'(n_sq[i]);
			end
			p_s34  <= p_sq;
			cf_s34 <= cf_sq;
		end
	end

	// ---------------- stage 35: sum and output saturation
	logic signed [NMW-1:0]  nm    [3];
	logic signed [NMW-1:0]  nm_sh [3];
	logic signed [PARW-1:0] par   [3];
	logic signed [OW-1:0]   o_sum [3];
	logic signed [QW-1:0]   o_x   [3];
	logic signed [QW-1:0]   o_c   [3];
	logic [2:0]             o_clip;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// negate before the floor shift
			nm[i]    = -NMW'(rn_s34[i]);
			nm_sh[i] = nm[i] >>> FR;
			par[i]   = PARW'(nm_sh[i]);
			o_sum[i] = OW'(p_s34[i]) + OW'(par[i]);
			o_x[i]   = QW'(o_sum[i]);
			o_clip[i] = 1'b0;
			if (o_x[i] > O_HI) begin
				o_c[i]    = O_HI;
				o_clip[i] = 1'b1;
			end else if (o_x[i] < O_LO) begin
				o_c[i]    = O_LO;
				o_clip[i] = 1'b1;
			end else begin
				o_c[i] = o_x[i];
			end
		end
	end

	logic signed [OUTW-1:0] ref_s35 [3];
	logic                   clip_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ref_s35[i] <= OUTW'(o_c[i]);
			end
			clip_s35 <= cf_s34 | (|o_clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
		end else if (en) begin
			v_s1  <= incident.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s34 <= sq_vld;
			v_s35 <= v_s34;
		end
	end

	assign refracted.valid   = v_s35;
	assign refracted.ref_x   = ref_s35[0];
	assign refracted.ref_y   = ref_s35[1];
	assign refracted.ref_z   = ref_s35[2];
	assign refracted.clipped = clip_s35;

	// ---------------- checks
	`VRU_ASSERT_IMPL(a_hold_on_stall, clk, arst_n, refracted.valid && !refracted.ready, !incident.ready, "ray taken while a result is stalled")
	`VRU_ASSERT_IMPL(a_ready_cause, clk, arst_n, !incident.ready, refracted.valid, "ray refused with no result waiting")
	`VRU_ASSERT(a_cos_bound, clk, arst_n, !v_s2 || (c_s2 <= C_ONE_C), "cosine above one after clamp")

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector refraction unit. Rays go in on the
// incident channel with random gaps. Results are taken from the refracted
// channel under random back-pressure. A short table of corner rays runs first.
// Every result beat is compared in order against the hand-derived answer that
// its corner row carries, or else against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CW          = 16;
	localparam int N_RANDOM    = 1300;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_BURST  = 80;
	localparam int DRAIN_AT    = 800;
	localparam longint LIMIT   = 64'd20_000_000;

	typedef struct {
		logic signed [CW-1:0]             dir_x, dir_y, dir_z;
		logic signed [CW-1:0]             norm_x, norm_y, norm_z;
		logic        [vru_pkg::ETA_W-1:0] eta;
	} ray_t;

	typedef struct {
		logic signed [vru_pkg::OUT_W-1:0] ref_x, ref_y, ref_z;
		logic                             clipped;
	} bent_t;

	typedef struct packed {
		logic [CW-1:0]             dx, dy, dz, nx, ny, nz;
		logic [vru_pkg::ETA_W-1:0] eta;
		logic                      has_exp;
		logic [vru_pkg::OUT_W-1:0] ex, ey, ez;
		logic                      ec;
	} corner_row_t;

	localparam int NCORNER = 16;

	// dx dy dz | nx ny nz | eta | has_exp ex ey ez clipped
	localparam corner_row_t CORNERS [NCORNER] = '{
		// all zero: no perpendicular part, root of one along a zero normal
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
			1'b1, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// head-on ray at ratio one passes straight through
		'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd8192,
			1'b1, 20'sd0, 20'sd0, -20'sd16384, 1'b0},
		// all components at the minimum, largest ratio: saturates high
		'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF,
			1'b1, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b1},
		// all components at the maximum, largest ratio: saturates low
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF,
			1'b1, 20'h80000, 20'h80000, 20'h80000, 1'b1},
		// cosine above one gets clamped
		'{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sh7FFF, 16'd8192,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// glancing ray into a thinner medium: negative radicand
		'{16'sd15565, 16'sd0, -16'sd5117, 16'sd0, 16'sd0, 16'sd16384, 16'd16384,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// zero normal
		'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd8192,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// zero ratio
		'{16'sd0, 16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd0,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// largest ratio on a unit ray
		'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'hFFFF,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// smallest nonzero ratio
		'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd1,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		'{16'sh8000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd8192,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		'{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'd8192,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		'{16'sd9459, -16'sd9459, -16'sd9459, 16'sd0, 16'sd0, 16'sd16384, 16'h8000,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// ray leaving along the normal
		'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd8192,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0},
		// zero direction
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd8192,
			1'b0, 20'sd0, 20'sd0, 20'sd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	vru_in_if #(.COMP_WIDTH(CW)) ray_if ();
	vru_out_if                   bent_if ();

	vector_refraction_unit #(.COMP_WIDTH(CW)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.incident  (ray_if),
		.refracted (bent_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bent_t bent_q [$];
	bit    typed_on;
	bent_t typed_bent;
	bit    hold_off_req;
	int    errors;
	int    rays_taken;
	int    results_seen;
	int    clipped_seen;

	// --------------------------------------------------------------- predictor

	function automatic longint clamp_sat(input longint v, input longint lo,
			input longint hi, inout bit sat);
		if (v < lo) begin
			sat = 1'b1;
			return lo;
		end
		if (v > hi) begin
			sat = 1'b1;
			return hi;
		end
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned root;
		longint unsigned bit_v;
		root  = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= root + bit_v) begin
				x    -= root + bit_v;
				root  = (root >> 1) + bit_v;
			end else begin
				root >>= 1;
			end
			bit_v >>= 2;
		end
		return root;
	endfunction

	function automatic bent_t refract_ray(input ray_t r);
		longint d [3];
		longint n [3];
		longint p [3];
		longint o [3];
		longint eta, c, w, sq, rad;
		longint unsigned root;
		bit sat;
		bent_t res;
		d[0] = longint'(r.dir_x);
		d[1] = longint'(r.dir_y);
		d[2] = longint'(r.dir_z);
		n[0] = longint'(r.norm_x);
		n[1] = longint'(r.norm_y);
		n[2] = longint'(r.norm_z);
		eta  = longint'(r.eta);
		sat  = 1'b0;
		sq   = 0;
		// exact q.28 dot product floored to q.14, negated into the cosine
		c = -((d[0] * n[0] + d[1] * n[1] + d[2] * n[2]) >>> vru_pkg::FRAC_W);
		if (c > vru_pkg::ONE)
			c = vru_pkg::ONE;
		c = clamp_sat(c, vru_pkg::C_MIN, c, sat);
		for (int i = 0; i < 3; i++) begin
			w    = clamp_sat(d[i] + ((c * n[i]) >>> vru_pkg::FRAC_W),
				-vru_pkg::W_LIM, vru_pkg::W_LIM, sat);
			p[i] = clamp_sat((eta * w) >>> vru_pkg::ETA_FRAC_W,
				-vru_pkg::P_LIM, vru_pkg::P_LIM, sat);
			sq  += p[i] * p[i];
		end
		rad = vru_pkg::RAD_ONE - sq;
		if (rad < 0)
			rad = -rad;
		root = floor_sqrt(longint'(rad));
		for (int i = 0; i < 3; i++)
			o[i] = clamp_sat(p[i] + ((-(longint'(root) * n[i])) >>> vru_pkg::FRAC_W),
				vru_pkg::OUT_MIN, vru_pkg::OUT_MAX, sat);
		res.ref_x   = o[0][vru_pkg::OUT_W-1:0];
		res.ref_y   = o[1][vru_pkg::OUT_W-1:0];
		res.ref_z   = o[2][vru_pkg::OUT_W-1:0];
		res.clipped = sat;
		return res;
	endfunction

	// --------------------------------------------------------------- stimulus

	function automatic void unit_vec(output logic signed [CW-1:0] x,
			output logic signed [CW-1:0] y, output logic signed [CW-1:0] z);
		real a, b, c, len;
		do begin
			a   = real'($urandom_range(0, 65536)) / 32768.0 - 1.0;
			b   = real'($urandom_range(0, 65536)) / 32768.0 - 1.0;
			c   = real'($urandom_range(0, 65536)) / 32768.0 - 1.0;
			len = $sqrt(a * a + b * b + c * c);
		end while (len < 0.05 || len > 1.0);
		x = CW'($rtoi(a / len * 16384.0));
		y = CW'($rtoi(b / len * 16384.0));
		z = CW'($rtoi(c / len * 16384.0));
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		int kind;
		longint dot;
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			unit_vec(r.dir_x, r.dir_y, r.dir_z);
			unit_vec(r.norm_x, r.norm_y, r.norm_z);
			dot = longint'(r.dir_x) * r.norm_x + longint'(r.dir_y) * r.norm_y
				+ longint'(r.dir_z) * r.norm_z;
			// mostly face the normal against the ray, as a tracer does
			if (dot > 0 && kind < 60) begin
				r.norm_x = -r.norm_x;
				r.norm_y = -r.norm_y;
				r.norm_z = -r.norm_z;
			end
			r.eta = (kind < 60) ? vru_pkg::ETA_W'($urandom_range(4096, 16384))
				: vru_pkg::ETA_W'($urandom_range(0, 65535));
		end else begin
			r.dir_x  = CW'($urandom);
			r.dir_y  = CW'($urandom);
			r.dir_z  = CW'($urandom);
			r.norm_x = CW'($urandom);
			r.norm_y = CW'($urandom);
			r.norm_z = CW'($urandom);
			r.eta    = vru_pkg::ETA_W'($urandom);
		end
		return r;
	endfunction

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_ray(input ray_t r, input bit has_exp, input bent_t e);
		@(negedge clk);
		ray_if.valid     <= 1'b1;
		ray_if.dir_x     <= r.dir_x;
		ray_if.dir_y     <= r.dir_y;
		ray_if.dir_z     <= r.dir_z;
		ray_if.norm_x    <= r.norm_x;
		ray_if.norm_y    <= r.norm_y;
		ray_if.norm_z    <= r.norm_z;
		ray_if.eta_ratio <= r.eta;
		typed_on          = has_exp;
		typed_bent        = e;
		do
			@(posedge clk);
		while (!ray_if.ready);
	endtask

	task automatic idle_in(input int cycles);
		@(negedge clk);
		ray_if.valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// --------------------------------------------------------------- checking

	always @(posedge clk) begin : scoreboard
		bent_t got;
		bent_t want;
		if (arst_n) begin
			if (bent_if.valid && bent_if.ready) begin
				got.ref_x   = bent_if.ref_x;
				got.ref_y   = bent_if.ref_y;
				got.ref_z   = bent_if.ref_z;
				got.clipped = bent_if.clipped;
				results_seen++;
				if (got.clipped)
					clipped_seen++;
				if (bent_q.size() == 0) begin
					$display("%0t: result beat with nothing pending (%0d %0d %0d %0b)",
						$realtime, got.ref_x, got.ref_y, got.ref_z, got.clipped);
					errors++;
				end else begin
					want = bent_q.pop_front();
					if (got.ref_x !== want.ref_x) begin
						$display("%0t: ref_x expected %0d got %0d", $realtime,
							want.ref_x, got.ref_x);
						errors++;
					end
					if (got.ref_y !== want.ref_y) begin
						$display("%0t: ref_y expected %0d got %0d", $realtime,
							want.ref_y, got.ref_y);
						errors++;
					end
					if (got.ref_z !== want.ref_z) begin
						$display("%0t: ref_z expected %0d got %0d", $realtime,
							want.ref_z, got.ref_z);
						errors++;
					end
					if (got.clipped !== want.clipped) begin
						$display("%0t: clipped expected %0b got %0b", $realtime,
							want.clipped, got.clipped);
						errors++;
					end
				end
			end
			if (ray_if.valid && ray_if.ready) begin
				rays_taken++;
				if (typed_on)
					bent_q.push_back(typed_bent);
				else
					bent_q.push_back(refract_ray('{ray_if.dir_x, ray_if.dir_y,
						ray_if.dir_z, ray_if.norm_x, ray_if.norm_y, ray_if.norm_z,
						ray_if.eta_ratio}));
			end
		end
	end

	// --------------------------------------------------------------- receiver

	initial begin : receiver
		int  stall_left;
		int  phase_left;
		bit  rx_gaps_on;
		stall_left     = 0;
		phase_left     = 0;
		rx_gaps_on     = 1'b1;
		bent_if.ready  = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(100, 300);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			phase_left--;
			if (hold_off_req) begin
				// long hold-off so the pipeline backs up into the ray channel
				bent_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_off_req = 1'b0;
			end else if (stall_left > 0) begin
				bent_if.ready <= 1'b0;
				stall_left--;
			end else begin
				bent_if.ready <= 1'b1;
				if (rx_gaps_on && $urandom_range(0, 99) < 25)
					stall_left = idle_len();
			end
		end
	end

	// --------------------------------------------------------------- main

	initial begin : main
		ray_t  r;
		bent_t e;
		bit    gaps_on;
		errors           = 0;
		rays_taken       = 0;
		results_seen     = 0;
		clipped_seen     = 0;
		typed_on         = 1'b0;
		hold_off_req     = 1'b0;
		gaps_on          = 1'b1;
		arst_n           = 1'b0;
		ray_if.valid     = 1'b0;
		ray_if.dir_x     = '0;
		ray_if.dir_y     = '0;
		ray_if.dir_z     = '0;
		ray_if.norm_x    = '0;
		ray_if.norm_y    = '0;
		ray_if.norm_z    = '0;
		ray_if.eta_ratio = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < NCORNER; k++) begin
			r.dir_x     = CORNERS[k].dx;
			r.dir_y     = CORNERS[k].dy;
			r.dir_z     = CORNERS[k].dz;
			r.norm_x    = CORNERS[k].nx;
			r.norm_y    = CORNERS[k].ny;
			r.norm_z    = CORNERS[k].nz;
			r.eta       = CORNERS[k].eta;
			e.ref_x     = CORNERS[k].ex;
			e.ref_y     = CORNERS[k].ey;
			e.ref_z     = CORNERS[k].ez;
			e.clipped   = CORNERS[k].ec;
			send_ray(r, CORNERS[k].has_exp, e);
			if ($urandom_range(0, 3) == 0)
				idle_in(idle_len());
		end

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 100 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (k == HOLD_AT)
				hold_off_req = 1'b1;
			// sender stops until the pipeline has fully drained
			if (k == DRAIN_AT) begin
				idle_in(1);
				wait (bent_q.size() == 0);
			end
			r = random_ray();
			send_ray(r, 1'b0, e);
			if (gaps_on && !(k >= HOLD_AT && k < HOLD_AT + HOLD_BURST)
					&& $urandom_range(0, 99) < 30)
				idle_in(idle_len());
		end
		idle_in(1);

		wait (bent_q.size() == 0);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		$display("rays accepted: %0d, results checked: %0d, saturated results: %0d",
			rays_taken, results_seen, clipped_seen);
		$display("covered corner rays, unit and raw random rays, back-pressure and drain");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT);
		$display("timeout with %0d results still pending", bent_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
